@@ rtl/core/plc_dt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plc_dt_pkg
// Types and constants shared by the PLC delay timer core and its top level.
// ----------------------------------------------------------------------------
package plc_dt_pkg;

	localparam int DELAY_W = 32;
	localparam int MODE_W  = 3;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// output bit survives this mask unchanged
	localparam logic [1:0] CACHE_AND_OUT = 2'(2 + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_ON_DELAY    = 3'd0,
		MODE_OFF_DELAY   = 3'd1,
		MODE_AFTER_DELAY = 3'd2,
		MODE_DEBOUNCE    = 3'd3,
		MODE_AUTO_RESET  = 3'd4
	} mode_t;

	typedef enum logic {
		FUNC_EVAL = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	localparam logic REG_TIMER_MODE = 1'b0;

	typedef struct packed {
		logic               func;
		logic               level;
		logic [DELAY_W-1:0] delay_ticks;
	} item_t;

	typedef struct packed {
		logic out_nxt;
		logic active;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/core/plc_dt_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plc_dt_core
// Timer state (cached level, output, countdown) and the logic that updates it.
// ----------------------------------------------------------------------------
module plc_dt_core import plc_dt_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MODE_W-1:0] mode,
	input  wire item_t             item,
	input  wire logic              fire,
	output stat_t                  stat
);

	logic                   cached_q, out_q, active_q;
	logic [COUNT_WIDTH-1:0] remaining_q;
	logic                   cached_d, out_d, active_d;
	logic [COUNT_WIDTH-1:0] remaining_d;
	logic [COUNT_WIDTH-1:0] load_val;

	generate
		if (COUNT_WIDTH < DELAY_W) begin : g_sat
			assign load_val = (|item.delay_ticks[DELAY_W-1:COUNT_WIDTH]) ? '1 :
				item.delay_ticks[COUNT_WIDTH-1:0];
		end else begin : g_ext
			assign load_val = COUNT_WIDTH'(item.delay_ticks);
		end
	endgenerate

	always_comb begin
		logic lv;
		lv          = item.level;
		cached_d    = cached_q;
		out_d       = out_q;
		active_d    = active_q;
		remaining_d = remaining_q;
		if (item.func == FUNC_TICK) begin
			if (active_q) begin
				if (remaining_q <= COUNT_WIDTH'(1)) begin
					remaining_d = '0;
					active_d    = 1'b0;
					out_d       = ~out_q;
				end else begin
					remaining_d = remaining_q - COUNT_WIDTH'(1);
				end
			end
		end else begin
			case (mode_t'(mode))
				MODE_ON_DELAY: begin
					if (lv && !cached_q) begin
						remaining_d = load_val;
						active_d    = 1'b1;
						cached_d    = 1'b1;
					end else if (!lv && cached_q) begin
						remaining_d = '0;
						active_d    = 1'b0;
						cached_d    = 1'b0;
						out_d       = 1'b0;
					end
				end
				MODE_OFF_DELAY: begin
					if (!lv && cached_q) begin
						remaining_d = load_val;
						active_d    = 1'b1;
						cached_d    = 1'b0;
					end else if (lv && !cached_q) begin
						remaining_d = '0;
						active_d    = 1'b0;
						cached_d    = 1'b1;
						out_d       = 1'b1;
					end
				end
				MODE_AFTER_DELAY: begin
					if (!lv && cached_q) begin
						remaining_d = load_val;
						active_d    = 1'b1;
						out_d       = 1'b1;
						cached_d    = 1'b0;
					end else if (lv && !cached_q) begin
						cached_d = 1'b1;
					end
				end
				MODE_DEBOUNCE: begin
					if (lv != cached_q) begin
						if (lv != out_q) begin
							remaining_d = load_val;
							active_d    = 1'b1;
						end else begin
							remaining_d = '0;
							active_d    = 1'b0;
						end
						cached_d = lv;
					end
				end
				MODE_AUTO_RESET: begin
					if (lv && !cached_q) begin
						remaining_d = load_val;
						active_d    = 1'b1;
						cached_d    = 1'b1;
						out_d       = 1'b1;
					end else if (!lv && cached_q) begin
						remaining_d = '0;
						active_d    = 1'b0;
						cached_d    = 1'b0;
						out_d       = 1'b0;
					end
				end
				default: begin
					// unused modes leave the state alone on evaluate
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_q    <= 1'b0;
			out_q       <= 1'b0;
			active_q    <= 1'b0;
			remaining_q <= '0;
		end else if (fire) begin
			cached_q    <= cached_d;
			out_q       <= out_d;
			active_q    <= active_d;
			remaining_q <= remaining_d;
		end
	end

	assign stat.out_nxt = out_d & CACHE_AND_OUT[0];
	assign stat.active  = active_q;

endmodule
`default_nettype wire

@@ rtl/core/plc_delay_timer_block.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plc_delay_timer_block
// PLC delay timer: on-delay, off-delay, after-delay, debounce, auto-reset.
// ----------------------------------------------------------------------------
// An accepted request passes the input register, then the result register (out_valid).
// Throughput: 1 request per cycle while out_ready stays high; the state update is combinational.
// One request is taken into the input register while a result waits.
// Reset: arst_n async, clears mode, timer state and both valid flags.
module plc_delay_timer_block import plc_dt_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               func,
	input  wire logic               level,
	input  wire logic [DELAY_W-1:0] delay_ticks,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               out_level,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [APB_AW-1:0]  paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output      logic [APB_DW-1:0]  prdata,
	output      logic               pready
);

	logic [MODE_W-1:0] mode_q;
	item_t             item_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              out_level_q;
	logic              advance, fire;
	stat_t             stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMER_MODE) ?
		{{(APB_DW-MODE_W){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ON_DELAY;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMER_MODE) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{func: func, level: level, delay_ticks: delay_ticks};
		end
	end

	plc_dt_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.mode  (mode_q),
		.item  (item_s1),
		.fire  (fire),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_level_q <= stat.out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;

`ifndef SYNTH
	// input side only stalls when both stages are full and the sink holds off
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a full pipeline");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed request produced no result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled request in input register changed");

	// a tick on an idle timer must not move the output
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.func == FUNC_TICK && !stat.active) |=>
		(out_level_q == $past(out_level_q) || !$past(out_valid_q)))
		else $error("idle tick changed the output");
`endif

endmodule
`default_nettype wire

@@ tb/sv/plc_delay_timer_block_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plc_delay_timer_block_test
// Self-checking bench for the PLC delay timer. A short table of directed
// requests walks every timer mode, an unused mode and the spare register.
// Random requests follow, phase by phase, each phase after a timer_mode write.
// Every result is checked against its typed table value or a cycle-free model of the timer state.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module plc_delay_timer_block_test;
	import plc_dt_pkg::*;

	localparam int N_PHASES   = 15;
	localparam int PHASE_REQS = 89;
	localparam int LONG_HOLD  = 150;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE     = 8;
	localparam int MAX_SHOWN  = 10;

	localparam logic               REG_SPARE      = 1'b1;
	localparam logic [MODE_W-1:0]  MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0]  MODE_UNUSED_HI = 3'd7;
	localparam logic [DELAY_W-1:0] D_MAX          = '1;

	typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

	// typed: want is the expected out_level; otherwise the model decides
	typedef struct packed {
		row_kind_t          kind;
		func_t              fn;
		logic               lv;
		logic [DELAY_W-1:0] dly;
		logic               typed;
		logic               want;
		logic               ridx;
		logic [MODE_W-1:0]  mval;
	} dir_row_t;

	localparam int N_DIR = 32;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// on-delay from reset
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b1, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd0,         1'b1, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b1, 1'b1, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b0, D_MAX,         1'b1, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd2,         1'b1, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd5,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_OFF_DELAY},
		'{ROW_REQ, FUNC_EVAL, 1'b0, D_MAX,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd0,         1'b1, 1'b1, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_AFTER_DELAY},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'd1,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd3,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_DEBOUNCE},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'd1,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd1,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_AUTO_RESET},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'd3,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		// unused mode: evaluates ignored, ticks still count down
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_UNUSED_HI},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_SPARE,      3'd0},
		'{ROW_REQ, FUNC_TICK, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'd5,         1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_CFG, FUNC_EVAL, 1'b0, 32'd0,         1'b0, 1'b0, REG_TIMER_MODE,
			MODE_ON_DELAY},
		'{ROW_REQ, FUNC_EVAL, 1'b0, 32'h8000_0000, 1'b0, 1'b0, REG_TIMER_MODE, 3'd0},
		'{ROW_REQ, FUNC_EVAL, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, REG_TIMER_MODE, 3'd0}
	};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               func        = 1'b0;
	logic               level       = 1'b0;
	logic [DELAY_W-1:0] delay_ticks = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic               out_level;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [APB_AW-1:0]  paddr       = '0;
	logic [APB_DW-1:0]  pwdata      = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	// timer model state
	logic [MODE_W-1:0]  mdl_mode   = '0;
	logic               mdl_cached = 1'b0;
	logic               mdl_out    = 1'b0;
	logic               mdl_active = 1'b0;
	logic [DELAY_W-1:0] mdl_left   = '0;

	logic out_level_q [$];
	logic want_level;
	bit   calm          = 1'b0;
	bit   long_hold_req = 1'b0;
	int   err_count     = 0;
	int   n_reqs        = 0;
	int   n_results     = 0;
	int   n_mode_writes = 0;
	int   idle_cycles   = 0;

	plc_delay_timer_block DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.level       (level),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_level   (out_level),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_SHOWN)
			$display("MISMATCH: %s", msg);
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return int'($urandom_range(10, 40));
		return int'($urandom_range(1, 3));
	endfunction

	// counter is as wide as delay_ticks, so no delay saturates
	function automatic void arm_countdown(input logic [DELAY_W-1:0] d);
		mdl_left   = d;
		mdl_active = 1'b1;
	endfunction

	function automatic void drop_countdown();
		mdl_left   = '0;
		mdl_active = 1'b0;
	endfunction

	// advance the timer model by one request, return the output bit after it
	function automatic logic timer_next(input logic f, input logic lv,
			input logic [DELAY_W-1:0] d);
		if (f == FUNC_TICK) begin
			if (mdl_active) begin
				if (mdl_left <= 1) begin
					drop_countdown();
					mdl_out = ~mdl_out;
				end else begin
					mdl_left = mdl_left - 1'b1;
				end
			end
		end else begin
			case (mdl_mode)
				MODE_ON_DELAY: begin
					if (lv && !mdl_cached) begin
						arm_countdown(d);
						mdl_cached = 1'b1;
					end else if (!lv && mdl_cached) begin
						drop_countdown();
						mdl_cached = 1'b0;
						mdl_out    = 1'b0;
					end
				end
				MODE_OFF_DELAY: begin
					if (!lv && mdl_cached) begin
						arm_countdown(d);
						mdl_cached = 1'b0;
					end else if (lv && !mdl_cached) begin
						drop_countdown();
						mdl_cached = 1'b1;
						mdl_out    = 1'b1;
					end
				end
				MODE_AFTER_DELAY: begin
					if (!lv && mdl_cached) begin
						arm_countdown(d);
						mdl_out    = 1'b1;
						mdl_cached = 1'b0;
					end else if (lv && !mdl_cached) begin
						mdl_cached = 1'b1;
					end
				end
				MODE_DEBOUNCE: begin
					if (lv != mdl_cached) begin
						if (lv != mdl_out)
							arm_countdown(d);
						else
							drop_countdown();
						mdl_cached = lv;
					end
				end
				MODE_AUTO_RESET: begin
					if (lv && !mdl_cached) begin
						arm_countdown(d);
						mdl_cached = 1'b1;
						mdl_out    = 1'b1;
					end else if (!lv && mdl_cached) begin
						drop_countdown();
						mdl_cached = 1'b0;
						mdl_out    = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		return mdl_out;
	endfunction

	// all tasks below start and end on a rising edge
	task automatic send_req(input logic f, input logic lv, input logic [DELAY_W-1:0] d,
			input logic typed, input logic want);
		int   n;
		logic guess;
		in_valid    <= 1'b1;
		func        <= f;
		level       <= lv;
		delay_ticks <= d;
		do @(posedge clk); while (!in_ready);
		guess = timer_next(f, lv, d);
		out_level_q.push_back(typed ? want : guess);
		n_reqs++;
		n = (!calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (out_level_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_AW-1:0] a, input logic [APB_DW-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_AW-1:0] a, output logic [APB_DW-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// register writes only with the pipe empty; read back the mode each time
	task automatic set_reg(input logic idx, input logic [MODE_W-1:0] val);
		logic [APB_DW-1:0] wd;
		logic [APB_DW-1:0] rd;
		wait_results();
		wd              = $urandom;
		wd[MODE_W-1:0]  = val;
		apb_write(APB_AW'({idx, 2'b00}), wd);
		if (idx == REG_TIMER_MODE) begin
			mdl_mode = val;
			n_mode_writes++;
		end
		@(posedge clk);
		apb_read(APB_AW'({REG_TIMER_MODE, 2'b00}), rd);
		if (rd !== APB_DW'(mdl_mode))
			note_error($sformatf("timer_mode reads %0h, expected %0h", rd, mdl_mode));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (out_level_q.size() == 0) begin
				note_error($sformatf("out_level %b with no request pending", out_level));
			end else begin
				want_level = out_level_q.pop_front();
				if (out_level !== want_level)
					note_error($sformatf("result %0d: expected out_level %b, got %b",
						n_results, want_level, out_level));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("plc_delay_timer_block_test: errors");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold on request
	initial begin : sink_side
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold          = LONG_HOLD;
			end else if (hold == 0 && !calm && $urandom_range(0, 5) == 0) begin
				hold = gap_len();
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int                 p;
		int                 k;
		logic [MODE_W-1:0]  m;
		logic               f;
		logic               lv;
		logic [DELAY_W-1:0] d;
		dir_row_t           r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			r = DIR_ROWS[i];
			if (r.kind == ROW_CFG)
				set_reg(r.ridx, r.mval);
			else
				send_req(r.fn, r.lv, r.dly, r.typed, r.want);
		end

		lv = mdl_cached;
		for (p = 0; p < N_PHASES; p++) begin
			if (p < 5)
				m = MODE_W'(p);
			else if (p == 5)
				m = MODE_UNUSED_LO;
			else if ($urandom_range(0, 7) == 0)
				m = MODE_W'($urandom_range(6, 7));
			else
				m = MODE_W'($urandom_range(0, 4));
			if (p == 8)
				set_reg(REG_SPARE, MODE_W'($urandom_range(0, 7)));
			set_reg(REG_TIMER_MODE, m);
			// phase 6: sender streams while the result side holds off
			calm = (p == 3 || p == 6);
			if (p == 6)
				long_hold_req = 1'b1;
			for (k = 0; k < PHASE_REQS; k++) begin
				if (p == 10 && k == PHASE_REQS / 2)
					wait_results();
				f = ($urandom_range(0, 1) == 0) ? FUNC_TICK : FUNC_EVAL;
				case ($urandom_range(0, 9))
					0: d = $urandom;
					1: d = $urandom_range(7, 60);
					default: d = $urandom_range(0, 6);
				endcase
				if (f == FUNC_TICK) begin
					send_req(f, 1'($urandom), $urandom, 1'b0, 1'b0);
				end else begin
					if ($urandom_range(0, 19) == 0)
						lv = 1'($urandom);
					else if ($urandom_range(0, 9) < 4)
						lv = ~lv;
					send_req(f, lv, d, 1'b0, 1'b0);
				end
			end
		end

		calm = 1'b0;
		wait_results();
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d requests, %0d results checked, %0d timer_mode writes,",
			n_reqs, n_results, n_mode_writes);
		$display("all five modes, unused modes, spare register, long output stall.");
		if (err_count == 0)
			$display("plc_delay_timer_block_test: clean");
		else
			$display("plc_delay_timer_block_test: errors");
		$finish;
	end

endmodule
`default_nettype wire
